// ===== design/assert_macros.svh =====
// assertion macros used by the filter core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define KAB_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define KAB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KAB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/kab_pkg.sv =====
// shared types, constants and helpers of the angle/bias kalman filter
package kab_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int COV_FRAC_DEF   = 28;
  localparam int ACC_PAD        = 4;

  localparam int MEAS_W    = 25;
  localparam int RATE_W    = 28;
  localparam int DT_W      = 16;
  localparam int OUT_W     = 32;
  localparam int NOISE_W   = 31;
  localparam int CFG_IDX_W = 2;

  // fraction bits of q16.16 values and of the q0.16 time step
  localparam int DT_FRAC = 16;
  // multiplier digit width
  localparam int DIGIT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 2'd2;

  localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST   = 31'd268435;
  localparam logic [NOISE_W-1:0] BIAS_NOISE_RST    = 31'd805306;
  localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 31'd8053064;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_ANG_PRED,
    OP_PBB_DT,
    OP_PAA_PRED,
    OP_PBB_PRED,
    OP_DIV_K0,
    OP_DIV_K1,
    OP_ANG_UPD,
    OP_BIAS_UPD,
    OP_PBA_UPD,
    OP_PBB_UPD,
    OP_PAA_UPD,
    OP_PAB_UPD
  } op_t;

  typedef struct packed {
    logic start;
    logic frac_shift;
  } mul_req_t;

  function automatic op_t op_next(input op_t op);
    op_t nxt;
    unique case (op)
      OP_ANG_PRED: nxt = OP_PBB_DT;
      OP_PBB_DT:   nxt = OP_PAA_PRED;
      OP_PAA_PRED: nxt = OP_PBB_PRED;
      OP_PBB_PRED: nxt = OP_DIV_K0;
      OP_DIV_K0:   nxt = OP_DIV_K1;
      OP_DIV_K1:   nxt = OP_ANG_UPD;
      OP_ANG_UPD:  nxt = OP_BIAS_UPD;
      OP_BIAS_UPD: nxt = OP_PBA_UPD;
      OP_PBA_UPD:  nxt = OP_PBB_UPD;
      OP_PBB_UPD:  nxt = OP_PAA_UPD;
      OP_PAA_UPD:  nxt = OP_PAB_UPD;
      OP_PAB_UPD:  nxt = OP_ANG_PRED;
      default:     nxt = OP_ANG_PRED;
    endcase
    return nxt;
  endfunction

  function automatic logic op_is_div(input op_t op);
    return (op == OP_DIV_K0) || (op == OP_DIV_K1);
  endfunction

endpackage

// ===== design/kalman_angle_bias_filter_core.sv =====
// top level of the two-state angle/bias kalman filter with its sequencer
//
// usage
// - input channel (in_valid / in_stall): one item is a measured angle (q9.16),
//   a gyro rate (q12.16) and a time step (q0.16 s); it is taken when in_valid
//   is high and in_stall is low
// - result channel (out_valid / out_stall): one item per input, the filtered
//   angle and the gyro bias, both q16.16 saturated to 32 bits
// - cfg_we / cfg_index / cfg_data write the three noise registers; write only
//   while the filter is idle; an index past the last register is ignored
// - one item at a time: the next item is taken the cycle after the result is
//   taken; the one-bit-per-cycle divider runs twice per item and the
//   16-bit-digit multiplier is used ten times
// - reset clears angle, bias and covariance and loads the default noise
//   values; the filter comes up idle
// - while out_stall is high the result holds steady and in_stall stays high
`include "assert_macros.svh"

module kalman_angle_bias_filter_core #(
  parameter int DATA_WIDTH    = kab_pkg::DATA_WIDTH_DEF,
  parameter int COV_FRAC_BITS = kab_pkg::COV_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [kab_pkg::MEAS_W-1:0]   in_measured_angle,
  input  logic signed [kab_pkg::RATE_W-1:0]   in_angular_rate,
  input  logic        [kab_pkg::DT_W-1:0]     in_time_step,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [kab_pkg::OUT_W-1:0]    out_filtered_angle,
  output logic signed [kab_pkg::OUT_W-1:0]    out_rate_bias,
  input  logic                                cfg_we,
  input  logic        [kab_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [kab_pkg::NOISE_W-1:0]  cfg_data
);
  import kab_pkg::*;

  localparam int DW = DATA_WIDTH;
  // working width of sums and products, room for the capped product
  localparam int AW = ((DW > NOISE_W + 1) ? DW : NOISE_W + 1) + ACC_PAD;
  localparam int SW = AW + 1;
  localparam logic signed [SW-1:0] DW_HI = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] DW_LO = ~DW_HI;
  localparam logic signed [SW-1:0] O_HI  = {{(SW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [SW-1:0] O_LO  = ~O_HI;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] x);
    logic signed [DW-1:0] r;
    if (x > DW_HI) begin
      r = DW_HI[DW-1:0];
    end else if (x < DW_LO) begin
      r = DW_LO[DW-1:0];
    end else begin
      r = x[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SW-1:0] x);
    logic signed [OUT_W-1:0] r;
    if (x > O_HI) begin
      r = O_HI[OUT_W-1:0];
    end else if (x < O_LO) begin
      r = O_LO[OUT_W-1:0];
    end else begin
      r = x[OUT_W-1:0];
    end
    return r;
  endfunction

  // sequencer
  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  // filter state
  logic signed [DW-1:0] ang_r, ang_nxt;
  logic signed [DW-1:0] bias_r, bias_nxt;
  logic signed [DW-1:0] paa_r, paa_nxt;
  logic signed [DW-1:0] pab_r, pab_nxt;
  logic signed [DW-1:0] pba_r, pba_nxt;
  logic signed [DW-1:0] pbb_r, pbb_nxt;

  // noise registers
  logic [NOISE_W-1:0] an_r, an_nxt;
  logic [NOISE_W-1:0] bn_r, bn_nxt;
  logic [NOISE_W-1:0] mn_r, mn_nxt;

  // per-item working values
  logic signed [MEAS_W-1:0] meas_r, meas_nxt;
  logic signed [RATE_W-1:0] rate_r, rate_nxt;
  logic        [DT_W-1:0]   dt_r, dt_nxt;
  logic signed [AW-1:0]     p1_r, p1_nxt;
  logic signed [AW-1:0]     y_r, y_nxt;
  logic signed [DW-1:0]     k0_r, k0_nxt;
  logic signed [DW-1:0]     k1_r, k1_nxt;

  // shared units
  mul_req_t             mul_req;
  logic                 mul_fsh;
  logic signed [AW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  logic                 mul_done;
  logic signed [AW-1:0] mul_p;
  logic                 div_start;
  logic signed [DW-1:0] div_n;
  logic                 div_done;
  logic signed [DW-1:0] div_q;

  logic                 in_accept;
  logic                 unit_done;
  logic signed [SW-1:0] rate_sum;
  logic signed [DW-1:0] rate_sat;
  logic signed [AW-1:0] an_ext, bn_ext, mn_ext;
  logic signed [AW-1:0] inner;
  logic signed [AW-1:0] s_w;
  logic signed [SW-1:0] ydiff;
  logic signed [DW-1:0] dt_b;

  assign in_accept = in_valid && !in_stall;
  assign unit_done = mul_done || div_done;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  // result held in the state registers until taken
  assign out_filtered_angle = sat_out(SW'(ang_r));
  assign out_rate_bias      = sat_out(SW'(bias_r));

  // operand formation
  always_comb begin
    an_ext   = AW'($signed({1'b0, an_r}));
    bn_ext   = AW'($signed({1'b0, bn_r}));
    mn_ext   = AW'($signed({1'b0, mn_r}));
    dt_b     = DW'($signed({1'b0, dt_r}));
    rate_sum = SW'(rate_r) - SW'(bias_r);
    rate_sat = sat_dw(rate_sum);
    // angle variance growth term, old covariances
    inner    = p1_r - AW'(pab_r) - AW'(pba_r) + an_ext;
    // innovation variance
    s_w      = AW'(paa_r) + mn_ext;
    // innovation against the predicted angle
    ydiff    = SW'(meas_r) - SW'(ang_r);
    div_n    = (op_r == OP_DIV_K0) ? paa_r : pba_r;

    mul_a   = '0;
    mul_b   = '0;
    mul_fsh = 1'b0;
    unique case (op_r) inside
      OP_ANG_PRED: begin
        mul_a = AW'(rate_sat);
        mul_b = dt_b;
      end
      OP_PBB_DT: begin
        mul_a = AW'(pbb_r);
        mul_b = dt_b;
      end
      OP_PAA_PRED: begin
        mul_a = inner;
        mul_b = dt_b;
      end
      OP_PBB_PRED: begin
        mul_a = bn_ext;
        mul_b = dt_b;
      end
      OP_DIV_K0, OP_DIV_K1: begin
        mul_a = '0;
      end
      OP_ANG_UPD: begin
        mul_a   = y_r;
        mul_b   = k0_r;
        mul_fsh = 1'b1;
      end
      OP_BIAS_UPD: begin
        mul_a   = y_r;
        mul_b   = k1_r;
        mul_fsh = 1'b1;
      end
      OP_PBA_UPD: begin
        mul_a   = AW'(paa_r);
        mul_b   = k1_r;
        mul_fsh = 1'b1;
      end
      OP_PBB_UPD: begin
        mul_a   = AW'(pab_r);
        mul_b   = k1_r;
        mul_fsh = 1'b1;
      end
      OP_PAA_UPD: begin
        mul_a   = AW'(paa_r);
        mul_b   = k0_r;
        mul_fsh = 1'b1;
      end
      OP_PAB_UPD: begin
        mul_a   = AW'(pab_r);
        mul_b   = k0_r;
        mul_fsh = 1'b1;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // sequencer: issue one operation, wait for its unit, write back, repeat
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    mul_req   = '{start: 1'b0, frac_shift: mul_fsh};
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          op_nxt    = OP_ANG_PRED;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (op_is_div(op_r)) begin
          div_start = 1'b1;
        end else begin
          mul_req.start = 1'b1;
        end
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (unit_done) begin
          if (op_r == OP_PAB_UPD) begin
            state_nxt = ST_OUT;
          end else begin
            op_nxt    = op_next(op_r);
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // write-back of unit results and config writes
  always_comb begin
    ang_nxt  = ang_r;
    bias_nxt = bias_r;
    paa_nxt  = paa_r;
    pab_nxt  = pab_r;
    pba_nxt  = pba_r;
    pbb_nxt  = pbb_r;
    an_nxt   = an_r;
    bn_nxt   = bn_r;
    mn_nxt   = mn_r;
    meas_nxt = meas_r;
    rate_nxt = rate_r;
    dt_nxt   = dt_r;
    p1_nxt   = p1_r;
    y_nxt    = y_r;
    k0_nxt   = k0_r;
    k1_nxt   = k1_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ANGLE_NOISE:   an_nxt = cfg_data;
        CFG_BIAS_NOISE:    bn_nxt = cfg_data;
        CFG_MEASURE_NOISE: mn_nxt = cfg_data;
        default: begin
          an_nxt = an_r;
        end
      endcase
    end

    if (in_accept) begin
      meas_nxt = in_measured_angle;
      rate_nxt = in_angular_rate;
      dt_nxt   = in_time_step;
    end

    if ((state_r == ST_ISSUE) && (op_r == OP_DIV_K0)) begin
      y_nxt = ydiff[AW-1:0];
    end

    if ((state_r == ST_WAIT) && unit_done) begin
      unique case (op_r)
        OP_ANG_PRED: ang_nxt = sat_dw(SW'(ang_r) + SW'(mul_p));
        OP_PBB_DT:   p1_nxt  = mul_p;
        OP_PAA_PRED: begin
          paa_nxt = sat_dw(SW'(paa_r) + SW'(mul_p));
          pab_nxt = sat_dw(SW'(pab_r) - SW'(p1_r));
          pba_nxt = sat_dw(SW'(pba_r) - SW'(p1_r));
        end
        OP_PBB_PRED: pbb_nxt  = sat_dw(SW'(pbb_r) + SW'(mul_p));
        OP_DIV_K0:   k0_nxt   = div_q;
        OP_DIV_K1:   k1_nxt   = div_q;
        OP_ANG_UPD:  ang_nxt  = sat_dw(SW'(ang_r) + SW'(mul_p));
        OP_BIAS_UPD: bias_nxt = sat_dw(SW'(bias_r) + SW'(mul_p));
        // second row first, it needs the old paa and pab
        OP_PBA_UPD:  pba_nxt  = sat_dw(SW'(pba_r) - SW'(mul_p));
        OP_PBB_UPD:  pbb_nxt  = sat_dw(SW'(pbb_r) - SW'(mul_p));
        OP_PAA_UPD:  paa_nxt  = sat_dw(SW'(paa_r) - SW'(mul_p));
        OP_PAB_UPD:  pab_nxt  = sat_dw(SW'(pab_r) - SW'(mul_p));
        default: begin
          ang_nxt = ang_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_ANG_PRED;
      ang_r   <= '0;
      bias_r  <= '0;
      paa_r   <= '0;
      pab_r   <= '0;
      pba_r   <= '0;
      pbb_r   <= '0;
      an_r    <= ANGLE_NOISE_RST;
      bn_r    <= BIAS_NOISE_RST;
      mn_r    <= MEASURE_NOISE_RST;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      ang_r   <= ang_nxt;
      bias_r  <= bias_nxt;
      paa_r   <= paa_nxt;
      pab_r   <= pab_nxt;
      pba_r   <= pba_nxt;
      pbb_r   <= pbb_nxt;
      an_r    <= an_nxt;
      bn_r    <= bn_nxt;
      mn_r    <= mn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meas_r <= meas_nxt;
    rate_r <= rate_nxt;
    dt_r   <= dt_nxt;
    p1_r   <= p1_nxt;
    y_r    <= y_nxt;
    k0_r   <= k0_nxt;
    k1_r   <= k1_nxt;
  end

  kab_mul #(
    .DW   (DW),
    .AW   (AW),
    .FRAC (COV_FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  kab_div #(
    .DW   (DW),
    .AW   (AW),
    .FRAC (COV_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (div_n),
    .d     (s_w),
    .done  (div_done),
    .q     (div_q)
  );

  `KAB_ASSERT_ALWAYS(a_units_exclusive, !(mul_done && div_done), "multiplier and divider finished together")
  `KAB_ASSERT_IMPL(a_done_in_wait, (mul_done || div_done), (state_r == ST_WAIT), "unit finished outside wait")
  `KAB_ASSERT_NEXT(a_accept_issue, (in_valid && !in_stall), ((state_r == ST_ISSUE) && (op_r == OP_ANG_PRED)), "accepted item did not start prediction")

endmodule

// ===== design/kab_mul.sv =====
// shared digit-serial multiplier with round-to-nearest shift and magnitude cap
module kab_mul #(
  parameter int DW   = kab_pkg::DATA_WIDTH_DEF,
  parameter int AW   = kab_pkg::DATA_WIDTH_DEF + kab_pkg::ACC_PAD,
  parameter int FRAC = kab_pkg::COV_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kab_pkg::mul_req_t  req,
  input  logic signed [AW-1:0] a,
  input  logic signed [DW-1:0] b,
  output logic               done,
  output logic signed [AW-1:0] p
);
  import kab_pkg::*;

  localparam int ND = (DW + DIGIT_W - 1) / DIGIT_W;
  localparam int BW = ND * DIGIT_W;
  localparam int PW = AW + BW;
  localparam int CW = $clog2(ND + 1);
  localparam logic [PW:0] HALF_DT = (PW+1)'(1) << (DT_FRAC - 1);
  localparam logic [PW:0] HALF_FR = (PW+1)'(1) << (FRAC - 1);
  localparam logic [PW:0] CAP_MAG = (PW+1)'(1) << (AW - 2);

  logic [AW-1:0] amag_r, amag_nxt;
  logic [BW-1:0] bmag_r, bmag_nxt;
  logic [PW-1:0] acc_r, acc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic          fsh_r, fsh_nxt;
  logic          busy_r, busy_nxt;
  logic          fin_r, fin_nxt;
  logic          done_r;
  logic signed [AW-1:0] p_r, p_nxt;

  logic [AW-1:0]         a_abs;
  logic [DW-1:0]         b_abs;
  logic [AW+DIGIT_W-1:0] pp;
  logic [PW:0]           rnd;
  logic [PW:0]           shd;
  logic [AW-1:0]         mag;

  assign a_abs = a[AW-1] ? (~$unsigned(a) + 1'b1) : $unsigned(a);
  assign b_abs = b[DW-1] ? (~$unsigned(b) + 1'b1) : $unsigned(b);
  assign pp    = amag_r * bmag_r[BW-1 -: DIGIT_W];

  // round half away from zero on the magnitude, then cap
  always_comb begin
    rnd = {1'b0, acc_r} + (fsh_r ? HALF_FR : HALF_DT);
    shd = fsh_r ? (rnd >> FRAC) : (rnd >> DT_FRAC);
    mag = (shd > CAP_MAG) ? AW'(CAP_MAG) : AW'(shd);
  end

  always_comb begin
    amag_nxt = amag_r;
    bmag_nxt = bmag_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    fsh_nxt  = fsh_r;
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    p_nxt    = p_r;
    if (req.start) begin
      amag_nxt = a_abs;
      bmag_nxt = BW'(b_abs);
      acc_nxt  = '0;
      cnt_nxt  = CW'(ND);
      neg_nxt  = a[AW-1] ^ b[DW-1];
      fsh_nxt  = req.frac_shift;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // most significant digit first
      acc_nxt  = {acc_r[PW-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + PW'(pp);
      bmag_nxt = {bmag_r[BW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
    if (fin_r) begin
      p_nxt = neg_r ? $signed(~mag + 1'b1) : $signed(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= fin_r;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amag_r <= amag_nxt;
    bmag_r <= bmag_nxt;
    acc_r  <= acc_nxt;
    neg_r  <= neg_nxt;
    fsh_r  <= fsh_nxt;
    p_r    <= p_nxt;
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

// ===== design/kab_div.sv =====
// radix-2 restoring divider for the fractional kalman gains, saturating
module kab_div #(
  parameter int DW   = kab_pkg::DATA_WIDTH_DEF,
  parameter int AW   = kab_pkg::DATA_WIDTH_DEF + kab_pkg::ACC_PAD,
  parameter int FRAC = kab_pkg::COV_FRAC_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] n,
  input  logic signed [AW-1:0] d,
  output logic                 done,
  output logic signed [DW-1:0] q
);
  import kab_pkg::*;

  localparam int NW = DW + FRAC;
  localparam int RW = ((FRAC > AW) ? FRAC : AW) + 1;
  localparam int CW = $clog2(DW + 1);
  localparam logic [DW-1:0] HALF_M = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MAX_P  = {1'b0, {(DW-1){1'b1}}};

  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] dmag_r, dmag_nxt;
  logic [DW-1:0] low_r, low_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic          ovf_r, ovf_nxt;
  logic          dz_r, dz_nxt;
  logic          busy_r, busy_nxt;
  logic          fin_r, fin_nxt;
  logic          done_r;
  logic signed [DW-1:0] q_r, q_nxt;

  logic [DW-1:0] n_abs;
  logic [AW-1:0] d_abs;
  logic [NW-1:0] num;
  logic [RW-1:0] rem0;
  logic [RW-1:0] trial;

  assign n_abs = n[DW-1] ? (~$unsigned(n) + 1'b1) : $unsigned(n);
  assign d_abs = d[AW-1] ? (~$unsigned(d) + 1'b1) : $unsigned(d);
  assign num   = {n_abs, {FRAC{1'b0}}};
  assign rem0  = RW'(num[NW-1:DW]);
  assign trial = {rem_r[RW-2:0], low_r[DW-1]};

  always_comb begin
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    ovf_nxt  = ovf_r;
    dz_nxt   = dz_r;
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    q_nxt    = q_r;
    if (start) begin
      rem_nxt  = rem0;
      dmag_nxt = RW'(d_abs);
      low_nxt  = num[DW-1:0];
      quo_nxt  = '0;
      cnt_nxt  = CW'(DW);
      neg_nxt  = n[DW-1] ^ d[AW-1];
      // quotient would need more than DW bits
      ovf_nxt  = rem0 >= RW'(d_abs);
      dz_nxt   = (d == '0);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= dmag_r) begin
        rem_nxt = trial - dmag_r;
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      low_nxt = {low_r[DW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
    if (fin_r) begin
      if (dz_r) begin
        q_nxt = '0;
      end else if (neg_r) begin
        q_nxt = (ovf_r || (quo_r > HALF_M)) ? $signed(HALF_M) : $signed(~quo_r + 1'b1);
      end else begin
        q_nxt = (ovf_r || quo_r[DW-1]) ? $signed(MAX_P) : $signed(quo_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= fin_r;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    low_r  <= low_nxt;
    quo_r  <= quo_nxt;
    neg_r  <= neg_nxt;
    ovf_r  <= ovf_nxt;
    dz_r   <= dz_nxt;
    q_r    <= q_nxt;
  end

  assign done = done_r;
  assign q    = q_r;

endmodule
